>>> hw/rtl/hnml_pkg.sv
// Shared types, character codes and method-word tables for the HTTP line
// normalizer and method lexer. No dependencies; every other file imports it.

package hnml_pkg;

  // Operation codes of an input beat.
  localparam logic [1:0] OP_BYTE   = 2'd0;
  localparam logic [1:0] OP_EOI    = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // Token kinds of a result beat.
  localparam logic [1:0] TK_CHAR   = 2'd0;
  localparam logic [1:0] TK_METHOD = 2'd1;
  localparam logic [1:0] TK_END    = 2'd2;

  // Method codes.
  localparam logic [2:0] M_HEAD    = 3'd0;
  localparam logic [2:0] M_GET     = 3'd1;
  localparam logic [2:0] M_PUT     = 3'd2;
  localparam logic [2:0] M_POST    = 3'd3;
  localparam logic [2:0] M_DELETE  = 3'd4;
  localparam logic [2:0] M_OPTIONS = 3'd5;
  localparam logic [2:0] M_CONNECT = 3'd6;
  localparam logic [2:0] M_TRACE   = 3'd7;

  // Special characters.
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_SP  = 8'h20;

  // Result slots per input beat; one beat causes at most two results.
  localparam int MaxRes = 3;

  typedef enum logic [2:0] {
    ST_START    = 3'd0,
    ST_METHOD   = 3'd1,
    ST_URL      = 3'd2,
    ST_RESPONSE = 3'd3,
    ST_FINISHED = 3'd4,
    ST_ERROR    = 3'd5
  } pstate_t;

  typedef struct packed {
    logic [1:0] token_kind;
    logic [7:0] char_value;
    logic [2:0] method_code;
    logic [2:0] lex_state;
    logic       last_of_run;
  } result_t;

  // Lexer state that a single character can change.
  typedef struct packed {
    pstate_t    ps;
    logic [2:0] sel;
    logic [2:0] pos;
  } lex_t;

  typedef struct packed {
    lex_t    st;
    logic    emit;
    result_t r;
  } lex_out_t;

  // Lower-case letter of a method word at a position; zero past its end.
  function automatic logic [7:0] word_char(input logic [2:0] sel, input logic [2:0] pos);
    logic [63:0] w;
    case (sel)
      M_HEAD:    w = {"head", 32'h0};
      M_GET:     w = {"get", 40'h0};
      M_PUT:     w = {"put", 40'h0};
      M_POST:    w = {"post", 32'h0};
      M_DELETE:  w = {"delete", 16'h0};
      M_OPTIONS: w = {"options", 8'h0};
      M_CONNECT: w = {"connect", 8'h0};
      default:   w = {"trace", 24'h0};
    endcase
    return w[8*(7-int'(pos)) +: 8];
  endfunction

  function automatic logic [2:0] word_len(input logic [2:0] sel);
    logic [2:0] l;
    case (sel)
      M_HEAD:    l = 3'd4;
      M_GET:     l = 3'd3;
      M_PUT:     l = 3'd3;
      M_POST:    l = 3'd4;
      M_DELETE:  l = 3'd6;
      M_OPTIONS: l = 3'd7;
      M_CONNECT: l = 3'd7;
      default:   l = 3'd5;
    endcase
    return l;
  endfunction

  // First method whose word opens with this letter; bit 3 flags a hit.
  function automatic logic [3:0] first_sel(input logic [7:0] lc);
    logic [3:0] f;
    case (lc)
      "h":     f = {1'b1, M_HEAD};
      "g":     f = {1'b1, M_GET};
      "p":     f = {1'b1, M_PUT};
      "d":     f = {1'b1, M_DELETE};
      "o":     f = {1'b1, M_OPTIONS};
      "c":     f = {1'b1, M_CONNECT};
      "t":     f = {1'b1, M_TRACE};
      default: f = 4'h0;
    endcase
    return f;
  endfunction

  function automatic result_t mk_result(input logic [1:0] kind, input logic [7:0] ch,
                                        input logic [2:0] code, input pstate_t ps);
    result_t r;
    r.token_kind  = kind;
    r.char_value  = ch;
    r.method_code = code;
    r.lex_state   = ps;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  // Lex one normalized character.
  function automatic lex_out_t lex_char(input lex_t s, input logic [7:0] c,
                                        input logic has_peek, input logic [7:0] peek);
    lex_out_t   o;
    logic [7:0] lc;
    logic [7:0] pl;
    logic [3:0] f;
    logic [2:0] len;
    logic [2:0] pos1;
    lc   = c | 8'h20;
    pl   = peek | 8'h20;
    f    = first_sel(lc);
    len  = word_len(s.sel);
    pos1 = s.pos + 3'd1;
    o.st   = s;
    o.emit = 1'b0;
    o.r    = '0;
    case (s.ps)
      ST_START: begin
        if (lc == "h" && has_peek && pl == "t") begin
          o.st.ps = ST_RESPONSE;
          o.emit  = 1'b1;
          o.r     = mk_result(TK_CHAR, c, M_HEAD, ST_RESPONSE);
        end else if (f[3]) begin
          o.st.ps  = ST_METHOD;
          o.st.sel = f[2:0];
          o.st.pos = 3'd1;
        end else begin
          o.st.ps  = ST_ERROR;
          o.st.pos = 3'd0;
          o.emit   = 1'b1;
          o.r      = mk_result(TK_METHOD, 8'h0, M_HEAD, ST_ERROR);
        end
      end
      ST_METHOD: begin
        if (s.sel == M_PUT && s.pos == 3'd1) begin
          // After P only U or O can follow.
          if (lc == "u") begin
            o.st.pos = 3'd2;
          end else if (lc == "o") begin
            o.st.sel = M_POST;
            o.st.pos = 3'd2;
          end else begin
            o.st.ps  = ST_ERROR;
            o.st.pos = 3'd0;
            o.emit   = 1'b1;
            o.r      = mk_result(TK_METHOD, 8'h0, M_HEAD, ST_ERROR);
          end
        end else if (s.pos < len && word_char(s.sel, s.pos) == lc) begin
          if (pos1 >= len) begin
            o.st.ps  = ST_URL;
            o.st.pos = 3'd0;
            o.emit   = 1'b1;
            o.r      = mk_result(TK_METHOD, 8'h0, s.sel, ST_URL);
          end else begin
            o.st.pos = pos1;
          end
        end else begin
          o.st.ps  = ST_ERROR;
          o.st.pos = 3'd0;
          o.emit   = 1'b1;
          o.r      = mk_result(TK_METHOD, 8'h0, s.sel, ST_ERROR);
        end
      end
      default: begin
        o.emit = 1'b1;
        o.r    = mk_result(TK_CHAR, c, M_HEAD, s.ps);
      end
    endcase
    return o;
  endfunction

endpackage

>>> hw/rtl/hnml_step.sv
// Normalizer and lexer state registers with the logic that handles one beat.
// Depends on hnml_pkg.

module hnml_step import hnml_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  logic [1:0]            op,
  input  logic [7:0]            data_byte,
  output result_t [MaxRes-1:0]  res,
  output logic [1:0]            res_n
);

  pstate_t    ps;
  logic [7:0] last_emitted;
  logic [7:0] held_byte;
  logic       held_valid;
  logic       cr_pending;
  logic [2:0] method_sel;
  logic [2:0] match_pos;

  lex_t       s;
  logic [7:0] last_emitted_next;
  logic [7:0] held_byte_next;
  logic       held_valid_next;
  logic       cr_pending_next;
  lex_out_t   lx;
  logic [7:0] c;
  logic       consumed;
  logic [1:0] n;

  // Next state and results for the beat in the input register.
  always_comb begin
    s                 = '{ps: ps, sel: method_sel, pos: match_pos};
    last_emitted_next = last_emitted;
    held_byte_next    = held_byte;
    held_valid_next   = held_valid;
    cr_pending_next   = cr_pending;
    lx                = '0;
    c                 = held_byte;
    consumed          = 1'b0;
    n                 = 2'd0;
    res               = '0;
    if (go) begin
      if (ps == ST_FINISHED) begin
        if (op != OP_NONE) begin
          res[n] = mk_result(TK_END, 8'h0, M_HEAD, ST_FINISHED);
          n      = n + 2'd1;
        end
      end else begin
        case (op)
          OP_FINISH: begin
            s.ps            = ST_FINISHED;
            s.pos           = 3'd0;
            held_valid_next = 1'b0;
            cr_pending_next = 1'b0;
            res[n]          = mk_result(TK_END, 8'h0, M_HEAD, ST_FINISHED);
            n               = n + 2'd1;
          end
          OP_EOI: begin
            // Flush the held byte without lookahead.
            if (held_valid) begin
              c                 = cr_pending ? CH_LF : held_byte;
              held_valid_next   = 1'b0;
              cr_pending_next   = 1'b0;
              last_emitted_next = c;
              lx                = lex_char(s, c, 1'b0, 8'h0);
              s                 = lx.st;
              if (lx.emit) begin
                res[n] = lx.r;
                n      = n + 2'd1;
              end
            end
            // An open method word ends as an error.
            if (s.ps == ST_METHOD) begin
              res[n] = mk_result(TK_METHOD, 8'h0,
                                 (s.sel == M_PUT && s.pos == 3'd1) ? M_HEAD : s.sel,
                                 ST_ERROR);
              n      = n + 2'd1;
              s.pos  = 3'd0;
            end
            s.ps   = ST_ERROR;
            res[n] = mk_result(TK_END, 8'h0, M_HEAD, ST_ERROR);
            n      = n + 2'd1;
          end
          OP_BYTE: begin
            if (!held_valid) begin
              held_byte_next  = data_byte;
              held_valid_next = 1'b1;
              cr_pending_next = (data_byte == CH_CR);
            end else if (cr_pending && data_byte == CH_LF) begin
              // CR LF collapses into one LF that is still held.
              held_byte_next  = CH_LF;
              cr_pending_next = 1'b0;
            end else begin
              c        = cr_pending ? CH_LF : held_byte;
              consumed = (c == CH_LF) && (last_emitted != CH_LF) &&
                         (data_byte inside {CH_SP, CH_TAB});
              if (consumed) begin
                c = CH_SP;
              end
              last_emitted_next = c;
              if (consumed) begin
                held_valid_next = 1'b0;
                cr_pending_next = 1'b0;
                held_byte_next  = 8'h0;
              end else begin
                held_byte_next  = data_byte;
                cr_pending_next = (data_byte == CH_CR);
              end
              lx = lex_char(s, c, !consumed, data_byte);
              s  = lx.st;
              if (lx.emit) begin
                res[n] = lx.r;
                n      = n + 2'd1;
              end
            end
          end
          default: begin
            n = 2'd0;
          end
        endcase
      end
      if (n != 2'd0) begin
        res[n - 2'd1].last_of_run = 1'b1;
      end
    end
    res_n = n;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ps           <= ST_START;
      last_emitted <= 8'h0;
      held_byte    <= 8'h0;
      held_valid   <= 1'b0;
      cr_pending   <= 1'b0;
      method_sel   <= 3'd0;
      match_pos    <= 3'd0;
    end else if (go) begin
      ps           <= s.ps;
      last_emitted <= last_emitted_next;
      held_byte    <= held_byte_next;
      held_valid   <= held_valid_next;
      cr_pending   <= cr_pending_next;
      method_sel   <= s.sel;
      match_pos    <= s.pos;
    end
  end

endmodule

>>> hw/rtl/hnml_out_fifo.sv
// Four-entry result queue that takes up to three results a cycle and
// delivers one beat a cycle while out_stall is low. Depends on hnml_pkg.

module hnml_out_fifo import hnml_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  result_t [MaxRes-1:0]  push_data,
  input  logic [1:0]            push_n,
  output logic                  space_ok,
  output logic                  out_valid,
  input  logic                  out_stall,
  output result_t               head
);

  result_t    mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       pop;

  // Room for a full burst is checked against the count alone.
  assign space_ok  = (count <= 3'd1);
  assign out_valid = (count != 3'd0);
  assign pop       = out_valid && !out_stall;
  assign head      = mem[rd_ptr];

  // Entry writes.
  always_ff @(posedge clk) begin
    for (int i = 0; i < MaxRes; i++) begin
      if (2'(i) < push_n) begin
        mem[wr_ptr + 2'(i)] <= push_data[i];
      end
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push_n;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count + {1'b0, push_n} - {2'b0, pop};
    end
  end

endmodule

>>> hw/rtl/http_line_normalizer_method_lexer_core.sv
// Top level of the HTTP line normalizer and method lexer.
// Depends on hnml_pkg, hnml_step and hnml_out_fifo.
//
//   Channel | Handshake          | Payload
//   --------+--------------------+------------------------------------------
//   input   | in_valid, in_stall | op, data_byte
//   output  | out_valid, out_stall | token_kind, char_value, method_code,
//           |                    | lex_state, last_of_run
//
// An accepted beat is held in the input register and handled there; its
// results (zero to two) are registered in the result queue and then shown at
// the output. One beat per cycle is sustained while each beat yields at most
// one result and out_stall is low; the output delivers one result beat per
// cycle while out_stall is low. Reset clears the lexer state and empties both
// stages. A stalled output lets results collect in the queue; once two or
// more wait, the input register holds its beat and raises in_stall.

module http_line_normalizer_method_lexer_core import hnml_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] op,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] token_kind,
  output logic [7:0] char_value,
  output logic [2:0] method_code,
  output logic [2:0] lex_state,
  output logic       last_of_run
);

  logic                 ir_valid;
  logic [1:0]           ir_op;
  logic [7:0]           ir_byte;
  logic                 space_ok;
  logic                 go;
  result_t [MaxRes-1:0] res;
  logic [1:0]           res_n;
  result_t              head;

  assign go       = ir_valid && space_ok;
  assign in_stall = ir_valid && !space_ok;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (!in_stall) begin
      ir_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ir_op   <= op;
      ir_byte <= data_byte;
    end
  end

  hnml_step u_step (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .op        (ir_op),
    .data_byte (ir_byte),
    .res       (res),
    .res_n     (res_n)
  );

  hnml_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_data (res),
    .push_n    (res_n),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  // Result fields of the head beat.
  assign token_kind  = head.token_kind;
  assign char_value  = head.char_value;
  assign method_code = head.method_code;
  assign lex_state   = head.lex_state;
  assign last_of_run = head.last_of_run;

endmodule

>>> tb/http_line_normalizer_method_lexer_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the HTTP line normalizer and method lexer core.
// Depends on hnml_pkg and the core; a scoreboard class predicts every token.

module http_line_normalizer_method_lexer_core_tb import hnml_pkg::*; ();

  // Method code carried by tokens that name no method.
  localparam logic [2:0] CODE_NONE = 3'd0;

  localparam int ITEMS       = 250;
  localparam int HOLD_CYCLES = 80;
  localparam int QUIET_LIMIT = 1000;
  localparam int TAIL_CYCLES = 16;

  // Tracks the lexer state, predicts the tokens of each accepted beat and
  // checks the tokens that leave the core against them in order.
  class method_lexer_scoreboard;
    string      verbs[8];
    result_t    tokens_due[$];
    pstate_t    ps;
    logic [7:0] last_out;
    logic [7:0] held;
    logic       held_valid;
    logic       cr_pending;
    logic [2:0] sel;
    logic [2:0] pos;
    int         errors;
    int         n_beats;
    int         n_ignored;
    int         n_folds;
    int         n_chars;
    int         n_methods;
    int         n_ends;

    function new();
      verbs = '{"head", "get", "put", "post", "delete", "options", "connect", "trace"};
      ps         = ST_START;
      last_out   = 8'h00;
      held       = 8'h00;
      held_valid = 1'b0;
      cr_pending = 1'b0;
      sel        = 3'd0;
      pos        = 3'd0;
    endfunction

    // Index of the first method word opening with this lower-case letter.
    function int verb_for(logic [7:0] lc);
      for (int i = 0; i < 8; i++) begin
        if (8'(verbs[i][0]) == lc) return i;
      end
      return -1;
    endfunction

    function void push(logic [1:0] kind, logic [7:0] ch, logic [2:0] code);
      result_t t;
      t.token_kind  = kind;
      t.char_value  = ch;
      t.method_code = code;
      t.lex_state   = ps;
      t.last_of_run = 1'b0;
      tokens_due.push_back(t);
      case (kind)
        TK_CHAR:   n_chars++;
        TK_METHOD: n_methods++;
        default:   n_ends++;
      endcase
    endfunction

    // Feed one normalized character to the method matcher.
    function void classify_char(logic [7:0] c, logic has_peek, logic [7:0] peek);
      logic [7:0] lc;
      int         v;
      lc = c | 8'h20;
      case (ps)
        ST_START: begin
          if (lc == "h" && has_peek && (peek | 8'h20) == "t") begin
            ps = ST_RESPONSE;
            push(TK_CHAR, c, CODE_NONE);
          end else begin
            v = verb_for(lc);
            if (v < 0) begin
              ps  = ST_ERROR;
              pos = 3'd0;
              push(TK_METHOD, 8'h00, CODE_NONE);
            end else begin
              ps  = ST_METHOD;
              sel = 3'(v);
              pos = 3'd1;
            end
          end
        end
        ST_METHOD: begin
          if (sel == M_PUT && pos == 3'd1) begin
            // After P only U or O keeps a word alive.
            if (lc == "u") begin
              pos = 3'd2;
            end else if (lc == "o") begin
              sel = M_POST;
              pos = 3'd2;
            end else begin
              ps  = ST_ERROR;
              pos = 3'd0;
              push(TK_METHOD, 8'h00, CODE_NONE);
            end
          end else if (pos < verbs[sel].len() && 8'(verbs[sel][int'(pos)]) == lc) begin
            pos = pos + 3'd1;
            if (pos >= verbs[sel].len()) begin
              ps  = ST_URL;
              pos = 3'd0;
              push(TK_METHOD, 8'h00, sel);
            end
          end else begin
            ps  = ST_ERROR;
            pos = 3'd0;
            push(TK_METHOD, 8'h00, sel);
          end
        end
        default: push(TK_CHAR, c, CODE_NONE);
      endcase
    endfunction

    // Note an accepted input beat and queue the tokens it must produce.
    function void note_beat(logic [1:0] beat_op, logic [7:0] b);
      logic [7:0] c;
      logic [2:0] code;
      logic       folded;
      int         n0;
      n0 = tokens_due.size();
      if (beat_op == OP_NONE) begin
        n_ignored++;
        return;
      end
      n_beats++;
      if (ps == ST_FINISHED) begin
        push(TK_END, 8'h00, CODE_NONE);
      end else if (beat_op == OP_FINISH) begin
        ps         = ST_FINISHED;
        held_valid = 1'b0;
        cr_pending = 1'b0;
        pos        = 3'd0;
        push(TK_END, 8'h00, CODE_NONE);
      end else if (beat_op == OP_EOI) begin
        // Flush the held byte without lookahead, then close any open word.
        if (held_valid) begin
          c          = cr_pending ? CH_LF : held;
          held_valid = 1'b0;
          cr_pending = 1'b0;
          last_out   = c;
          classify_char(c, 1'b0, 8'h00);
        end
        if (ps == ST_METHOD) begin
          code = (sel == M_PUT && pos == 3'd1) ? CODE_NONE : sel;
          ps   = ST_ERROR;
          pos  = 3'd0;
          push(TK_METHOD, 8'h00, code);
        end
        ps = ST_ERROR;
        push(TK_END, 8'h00, CODE_NONE);
      end else begin
        if (!held_valid) begin
          held       = b;
          held_valid = 1'b1;
          cr_pending = (b == CH_CR);
          return;
        end
        // A CR LF pair collapses into the held LF.
        if (cr_pending && b == CH_LF) begin
          held       = CH_LF;
          cr_pending = 1'b0;
          return;
        end
        c      = cr_pending ? CH_LF : held;
        folded = (c == CH_LF && last_out != CH_LF && (b == CH_SP || b == CH_TAB));
        if (folded) begin
          c = CH_SP;
          n_folds++;
        end
        last_out = c;
        if (folded) begin
          held_valid = 1'b0;
          cr_pending = 1'b0;
          held       = 8'h00;
        end else begin
          held       = b;
          cr_pending = (b == CH_CR);
        end
        classify_char(c, !folded, b);
      end
      if (tokens_due.size() > n0) tokens_due[tokens_due.size() - 1].last_of_run = 1'b1;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50) $display("%t mismatch: %s", $realtime, msg);
    endtask

    // Compare one output beat with the oldest expected token.
    task check_token(result_t got);
      result_t want;
      if (tokens_due.size() == 0) begin
        report($sformatf("token with none expected: kind %0d char %02h code %0d state %0d",
                         got.token_kind, got.char_value, got.method_code, got.lex_state));
        return;
      end
      want = tokens_due.pop_front();
      if (got.token_kind !== want.token_kind)
        report($sformatf("token_kind %0d, expected %0d", got.token_kind, want.token_kind));
      if (got.char_value !== want.char_value)
        report($sformatf("char_value %02h, expected %02h", got.char_value, want.char_value));
      if (got.method_code !== want.method_code)
        report($sformatf("method_code %0d, expected %0d", got.method_code, want.method_code));
      if (got.lex_state !== want.lex_state)
        report($sformatf("lex_state %0d, expected %0d", got.lex_state, want.lex_state));
      if (got.last_of_run !== want.last_of_run)
        report($sformatf("last_of_run %0d, expected %0d", got.last_of_run, want.last_of_run));
    endtask

    task finish_check();
      if (tokens_due.size() != 0)
        report($sformatf("%0d expected tokens never arrived", tokens_due.size()));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] op = OP_BYTE;
  logic [7:0] data_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] token_kind;
  logic [7:0] char_value;
  logic [2:0] method_code;
  logic [2:0] lex_state;
  logic       last_of_run;

  method_lexer_scoreboard sb;
  int    items_sent = 0;
  int    burst_left = 0;
  int    in_beats = 0;
  int    quiet_cycles = 0;
  logic  held_off = 1'b0;
  string opening;

  http_line_normalizer_method_lexer_core DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .token_kind  (token_kind),
    .char_value  (char_value),
    .method_code (method_code),
    .lex_state   (lex_state),
    .last_of_run (last_of_run)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Sample both channels at the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        sb.note_beat(op, data_byte);
        in_beats <= in_beats + 1;
      end
      if (out_valid && !out_stall)
        sb.check_token(result_t'({token_kind, char_value, method_code, lex_state, last_of_run}));
      quiet_cycles <= ((in_valid && !in_stall) || (out_valid && !out_stall)) ?
                      0 : quiet_cycles + 1;
    end
  end

  // Offer one beat in bursts with random gaps; returns after it is taken.
  task automatic feed(input logic [1:0] f_op, input logic [7:0] f_byte);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid  = 1'b1;
    op        = f_op;
    data_byte = f_byte;
    do @(posedge clk); while (in_stall);
    if (f_op != OP_NONE) items_sent++;
    @(negedge clk);
  endtask

  task automatic feed_str(input string s);
    for (int i = 0; i < s.len(); i++) feed(OP_BYTE, s[i]);
  endtask

  function automatic string mixed_case(input string s);
    string t;
    t = s;
    for (int i = 0; i < t.len(); i++) begin
      if (t[i] >= "a" && t[i] <= "z" && $urandom_range(0, 1)) t[i] = t[i] ^ 8'h20;
    end
    return t;
  endfunction

  function automatic logic [7:0] any_letter();
    return 8'($urandom_range(97, 122)) ^ ($urandom_range(0, 1) ? 8'h20 : 8'h00);
  endfunction

  // Random byte leaning on the characters that normalization cares about.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return CH_CR;
      1:       return CH_LF;
      2:       return CH_SP;
      3:       return CH_TAB;
      4, 5:    return any_letter();
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic field_value();
    int n;
    n = $urandom_range(0, 10);
    repeat (n) begin
      feed(OP_BYTE, ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) :
                                                  8'($urandom_range(8'h20, 8'h7e)));
    end
  endtask

  // One header line with a random line ending and sometimes a folded tail.
  task automatic header_line();
    int n;
    n = $urandom_range(1, 8);
    repeat (n) feed(OP_BYTE, any_letter());
    feed_str(": ");
    field_value();
    case ($urandom_range(0, 3))
      0:       feed_str("\n");
      1:       feed_str("\r");
      default: feed_str("\r\n");
    endcase
    if ($urandom_range(0, 3) == 0) begin
      feed(OP_BYTE, $urandom_range(0, 1) ? CH_SP : CH_TAB);
      field_value();
      feed_str("\r\n");
    end
  endtask

  // Receiver stall pattern, with one long hold-off once traffic is flowing.
  initial begin : receiver
    int mode;
    int seg;
    wait (!rst);
    forever begin
      if (!held_off && in_beats >= 60) begin
        held_off = 1'b1;
        @(negedge clk);
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
      end
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(8, 48);
      repeat (seg) begin
        @(negedge clk);
        case (mode)
          0:       out_stall = 1'b0;
          1:       out_stall = ($urandom_range(0, 3) == 0);
          2:       out_stall = ($urandom_range(0, 3) != 0);
          default: out_stall = ~out_stall;
        endcase
      end
    end
  end

  // Ends the run when neither channel moves for too long.
  initial begin : watchdog
    wait (!rst);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int         m;
    int         k;
    int         r;
    logic [7:0] b;
    sb = new();
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // The lexer leaves its start state once per run, so pick one opening.
    case ($urandom_range(0, 6))
      0, 1: begin
        m = $urandom_range(0, 7);
        opening = {"method ", sb.verbs[m]};
        feed_str(mixed_case({sb.verbs[m], " /x"}));
      end
      2: begin
        opening = "response line";
        feed_str(mixed_case("http/1.1 200"));
      end
      3: begin
        opening = "H without T";
        feed_str(mixed_case("hexd"));
      end
      4: begin
        opening = "P then a bad letter";
        feed_str(mixed_case("pa /"));
      end
      5: begin
        opening = "unknown first letter";
        do b = 8'($urandom_range(0, 255)); while (sb.verb_for(b | 8'h20) >= 0);
        feed(OP_BYTE, b);
        feed_str(" /");
      end
      default: begin
        m = $urandom_range(0, 7);
        k = $urandom_range(1, sb.verbs[m].len() - 1);
        opening = {"partial ", sb.verbs[m]};
        feed_str(mixed_case(sb.verbs[m].substr(0, k - 1)));
        if ($urandom_range(0, 1)) feed(OP_EOI, 8'h00);
        else feed(OP_BYTE, "z");
      end
    endcase

    // Directed normalization cases: lone CR, CR LF, folds by LF and by
    // CR LF, no fold after an LF, extreme bytes, ignored beat, end of input.
    feed_str("a\rb");
    feed_str("\r\nc");
    feed_str("\n d");
    feed_str("\r\n\t");
    feed_str("\n\n ");
    feed(OP_BYTE, 8'h00);
    feed(OP_BYTE, 8'hFF);
    feed(OP_NONE, 8'($urandom_range(0, 255)));
    feed_str("\r");
    feed(OP_EOI, 8'hFF);
    feed(OP_EOI, 8'h00);

    // Random traffic, mostly header lines with random content.
    while (items_sent < ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 55) header_line();
      else if (r < 93) feed(OP_BYTE, pick_byte());
      else if (r < 97) feed(OP_EOI, 8'($urandom_range(0, 255)));
      else feed(OP_NONE, 8'($urandom_range(0, 255)));
    end

    // Finish, then every kind of beat once more while finished.
    feed(OP_FINISH, 8'($urandom_range(0, 255)));
    feed(OP_BYTE, pick_byte());
    feed(OP_EOI, 8'($urandom_range(0, 255)));
    feed(OP_NONE, 8'($urandom_range(0, 255)));
    feed(OP_FINISH, 8'($urandom_range(0, 255)));
    in_valid = 1'b0;

    while (sb.tokens_due.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    sb.finish_check();

    $display("Run covered %0d input beats (%0d ignored, %0d line folds), opening: %s.",
             sb.n_beats, sb.n_ignored, sb.n_folds, opening);
    $display("Tokens checked: %0d characters, %0d method tokens, %0d end markers.",
             sb.n_chars, sb.n_methods, sb.n_ends);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/hnml_pkg.sv
hw/rtl/hnml_step.sv
hw/rtl/hnml_out_fifo.sv
hw/rtl/http_line_normalizer_method_lexer_core.sv
tb/http_line_normalizer_method_lexer_core_tb.sv
